[rtl/alucc_pkg.sv]
// shared types and codes for the alu with condition codes
package alucc_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned HALF_W = DATA_W / 2;
  localparam int unsigned SHAMT_W = 6;

  localparam logic [3:0] MODE_ADD = 4'd0;
  localparam logic [3:0] MODE_SUB = 4'd1;
  localparam logic [3:0] MODE_AND = 4'd2;
  localparam logic [3:0] MODE_XOR = 4'd3;
  localparam logic [3:0] MODE_SHL = 4'd4;
  localparam logic [3:0] MODE_SHR = 4'd5;
  localparam logic [3:0] MODE_SHL2 = 4'd6;
  localparam logic [3:0] MODE_SAR = 4'd7;
  localparam logic [3:0] MODE_MAX = 4'd8;
  localparam logic [3:0] MODE_MIN = 4'd9;
  localparam logic [3:0] MODE_MUL = 4'd10;

  localparam logic [3:0] COND_ALWAYS = 4'd0;
  localparam logic [3:0] COND_LE = 4'd1;
  localparam logic [3:0] COND_L = 4'd2;
  localparam logic [3:0] COND_E = 4'd3;
  localparam logic [3:0] COND_NE = 4'd4;
  localparam logic [3:0] COND_GE = 4'd5;
  localparam logic [3:0] COND_G = 4'd6;

  typedef struct packed {
    logic       upd;
    logic       upd_ovf;
    logic       ovf;
    logic [3:0] cond_sel;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              is_mul;
    logic [DATA_W-1:0] p_ll;
    logic [HALF_W-1:0] p_lh;
    logic [HALF_W-1:0] p_hl;
    ctl_t              ctl;
  } stage_t;

  typedef struct packed {
    logic zero;
    logic sign;
    logic overflow;
    logic cond;
  } flags_t;

endpackage

[rtl/alucc_exec.sv]
// first stage: function select, add overflow and multiply partial products
module alucc_exec (
  input  logic signed [alucc_pkg::DATA_W-1:0] a,
  input  logic signed [alucc_pkg::DATA_W-1:0] b,
  input  logic [3:0]                          mode,
  input  logic                                set_flags,
  input  logic [3:0]                          cond_sel,
  output alucc_pkg::stage_t                   stage
);

  logic [3:0]                           fn;
  logic [alucc_pkg::SHAMT_W-1:0]        sh;
  logic [alucc_pkg::DATA_W-1:0]         sum;
  logic [alucc_pkg::HALF_W-1:0]         a_lo;
  logic [alucc_pkg::HALF_W-1:0]         a_hi;
  logic [alucc_pkg::HALF_W-1:0]         b_lo;
  logic [alucc_pkg::HALF_W-1:0]         b_hi;
  logic                                 lt;

  assign fn = set_flags ? mode : alucc_pkg::MODE_ADD;
  assign sh = a[alucc_pkg::SHAMT_W-1:0];
  assign sum = a + b;
  assign lt = b < a;
  assign a_lo = a[alucc_pkg::HALF_W-1:0];
  assign a_hi = a[alucc_pkg::DATA_W-1:alucc_pkg::HALF_W];
  assign b_lo = b[alucc_pkg::HALF_W-1:0];
  assign b_hi = b[alucc_pkg::DATA_W-1:alucc_pkg::HALF_W];

  always_comb begin
    stage.res = '0;
    case (fn)
      alucc_pkg::MODE_ADD: stage.res = sum;
      alucc_pkg::MODE_SUB: stage.res = b - a;
      alucc_pkg::MODE_AND: stage.res = a & b;
      alucc_pkg::MODE_XOR: stage.res = a ^ b;
      alucc_pkg::MODE_SHL,
      alucc_pkg::MODE_SHL2: stage.res = b << sh;
      alucc_pkg::MODE_SHR: stage.res = b >> sh;
      alucc_pkg::MODE_SAR: stage.res = b >>> sh;
      alucc_pkg::MODE_MAX: stage.res = lt ? a : b;
      alucc_pkg::MODE_MIN: stage.res = lt ? b : a;
      default: stage.res = '0;
    endcase
    stage.is_mul = (fn == alucc_pkg::MODE_MUL);
    stage.p_ll = {{alucc_pkg::HALF_W{1'b0}}, a_lo} * {{alucc_pkg::HALF_W{1'b0}}, b_lo};
    stage.p_lh = a_lo * b_hi;
    stage.p_hl = a_hi * b_lo;
    stage.ctl.upd = set_flags;
    stage.ctl.upd_ovf = set_flags && (fn == alucc_pkg::MODE_ADD);
    stage.ctl.ovf = (a[alucc_pkg::DATA_W-1] == b[alucc_pkg::DATA_W-1])
                    && (sum[alucc_pkg::DATA_W-1] != a[alucc_pkg::DATA_W-1]);
    stage.ctl.cond_sel = cond_sel;
  end

endmodule

[rtl/alucc_flags.sv]
// condition code registers and branch condition check
module alucc_flags (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [alucc_pkg::DATA_W-1:0] res,
  input  alucc_pkg::ctl_t              ctl,
  output alucc_pkg::flags_t            flags_next
);

  logic zero_flag;
  logic sign_flag;
  logic overflow_flag;
  logic lt;

  always_comb begin
    flags_next.zero = ctl.upd ? (res == '0) : zero_flag;
    flags_next.sign = ctl.upd ? res[alucc_pkg::DATA_W-1] : sign_flag;
    flags_next.overflow = ctl.upd_ovf ? ctl.ovf : overflow_flag;
    lt = flags_next.sign ^ flags_next.overflow;
    case (ctl.cond_sel)
      alucc_pkg::COND_ALWAYS: flags_next.cond = 1'b1;
      alucc_pkg::COND_LE: flags_next.cond = lt | flags_next.zero;
      alucc_pkg::COND_L: flags_next.cond = lt;
      alucc_pkg::COND_E: flags_next.cond = flags_next.zero;
      alucc_pkg::COND_NE: flags_next.cond = !flags_next.zero;
      alucc_pkg::COND_GE: flags_next.cond = !lt;
      alucc_pkg::COND_G: flags_next.cond = !lt && !flags_next.zero;
      default: flags_next.cond = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_flag <= 1'b1;
      sign_flag <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (en) begin
      zero_flag <= flags_next.zero;
      sign_flag <= flags_next.sign;
      overflow_flag <= flags_next.overflow;
    end
  end

endmodule

[rtl/alu_with_condition_codes.sv]
// top level: 64-bit alu with condition codes, three register stages
// Takes one transaction per clock unless stalled. A transaction goes from the input register
// via the stage register to the result register, after a stage that picks the function and
// forms the 32x32 partial products of the multiply, and a stage that adds those partial
// products, updates the zero, sign and overflow flags in transaction order and evaluates the
// branch condition into the output register. Each stage holds its transaction while the next
// one is full and stalled, so in_stall rises only when all three registers are occupied.
module alu_with_condition_codes (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [alucc_pkg::DATA_W-1:0] operand_a,
  input  logic signed [alucc_pkg::DATA_W-1:0] operand_b,
  input  logic [3:0]                          mode,
  input  logic                                set_flags,
  input  logic [3:0]                          cond_sel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [alucc_pkg::DATA_W-1:0] result,
  output logic                                zero_out,
  output logic                                sign_out,
  output logic                                overflow_out,
  output logic                                cond_true
);

  logic                                s1_valid;
  logic signed [alucc_pkg::DATA_W-1:0] s1_a;
  logic signed [alucc_pkg::DATA_W-1:0] s1_b;
  logic [3:0]                          s1_mode;
  logic                                s1_set;
  logic [3:0]                          s1_cond;
  logic                                s2_valid;
  alucc_pkg::stage_t                   s2;
  alucc_pkg::stage_t                   stage_a;
  alucc_pkg::flags_t                   flags_next;
  logic [alucc_pkg::HALF_W-1:0]        cross_sum;
  logic [alucc_pkg::DATA_W-1:0]        res_b;
  logic                                out_free;
  logic                                s2_free;
  logic                                s1_free;
  logic                                s2_move;

  assign out_free = !out_valid || !out_stall;
  assign s2_free = !s2_valid || out_free;
  assign s1_free = !s1_valid || s2_free;
  assign s2_move = s2_valid && out_free;
  assign in_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_a <= operand_a;
      s1_b <= operand_b;
      s1_mode <= mode;
      s1_set <= set_flags;
      s1_cond <= cond_sel;
    end
  end

  alucc_exec u_exec (
    .a         (s1_a),
    .b         (s1_b),
    .mode      (s1_mode),
    .set_flags (s1_set),
    .cond_sel  (s1_cond),
    .stage     (stage_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2 <= stage_a;
    end
  end

  // low half of the multiply: cross products land in the upper 32 bits
  assign cross_sum = s2.p_lh + s2.p_hl;
  assign res_b = s2.is_mul ? s2.p_ll + {cross_sum, {alucc_pkg::HALF_W{1'b0}}} : s2.res;

  alucc_flags u_flags (
    .clk        (clk),
    .rst        (rst),
    .en         (s2_move),
    .res        (res_b),
    .ctl        (s2.ctl),
    .flags_next (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      result <= res_b;
      zero_out <= flags_next.zero;
      sign_out <= flags_next.sign;
      overflow_out <= flags_next.overflow;
      cond_true <= flags_next.cond;
    end
  end

endmodule

[rtl/alucc_chk.sv]
// port-level assertions for the alu with condition codes, bound to the top level
module alucc_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [alucc_pkg::DATA_W-1:0] operand_a,
  input logic signed [alucc_pkg::DATA_W-1:0] operand_b,
  input logic [3:0]                          mode,
  input logic                                set_flags,
  input logic [3:0]                          cond_sel,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [alucc_pkg::DATA_W-1:0] result,
  input logic                                zero_out,
  input logic                                sign_out,
  input logic                                overflow_out,
  input logic                                cond_true
);

  // no transaction comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // an empty output stage lets every pipeline stage advance
  a_no_stall_when_empty: assert property (
    @(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // zero and sign flags always come from the same result
  a_zero_not_sign: assert property (
    @(posedge clk) disable iff (rst) (out_valid && zero_out) |-> !sign_out)
    else $error("zero and sign flags both set");

  // a stalled result holds with its flags
  a_hold: assert property (
    @(posedge clk) disable iff (rst) (out_valid && out_stall) |=>
      (out_valid && $stable(result) && $stable(zero_out) && $stable(sign_out)
       && $stable(overflow_out) && $stable(cond_true)))
    else $error("stalled result changed");

endmodule

bind alu_with_condition_codes alucc_chk u_alucc_chk (.*);

[bench/alu_with_condition_codes_checker.sv]
// checker that predicts and compares every transaction of the alu with condition codes
module alu_with_condition_codes_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [alucc_pkg::DATA_W-1:0] operand_a,
  input  logic signed [alucc_pkg::DATA_W-1:0] operand_b,
  input  logic [3:0]                          mode,
  input  logic                                set_flags,
  input  logic [3:0]                          cond_sel,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [alucc_pkg::DATA_W-1:0] result,
  input  logic                                zero_out,
  input  logic                                sign_out,
  input  logic                                overflow_out,
  input  logic                                cond_true,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [alucc_pkg::DATA_W-1:0] value;
    logic                         zero;
    logic                         sign;
    logic                         overflow;
    logic                         cond;
  } alu_outcome_t;

  alu_outcome_t outcome_q[$];
  logic         cc_zero;
  logic         cc_sign;
  logic         cc_ovf;
  int           errors;
  int           compared;

  function automatic logic [alucc_pkg::DATA_W-1:0] alu_function(
      logic [3:0] fn, logic [alucc_pkg::DATA_W-1:0] a, logic [alucc_pkg::DATA_W-1:0] b);
    logic [alucc_pkg::SHAMT_W-1:0] sh;
    sh = a[alucc_pkg::SHAMT_W-1:0];
    case (fn)
      alucc_pkg::MODE_ADD: return a + b;
      alucc_pkg::MODE_SUB: return b - a;
      alucc_pkg::MODE_AND: return a & b;
      alucc_pkg::MODE_XOR: return a ^ b;
      alucc_pkg::MODE_SHL, alucc_pkg::MODE_SHL2: return b << sh;
      alucc_pkg::MODE_SHR: return b >> sh;
      alucc_pkg::MODE_SAR: return $signed(b) >>> sh;
      alucc_pkg::MODE_MAX: return ($signed(b) < $signed(a)) ? a : b;
      alucc_pkg::MODE_MIN: return ($signed(b) < $signed(a)) ? b : a;
      alucc_pkg::MODE_MUL: return a * b;
      default: return '0;
    endcase
  endfunction

  function automatic logic branch_taken(logic z, logic s, logic o, logic [3:0] sel);
    logic lt;
    lt = s ^ o;
    case (sel)
      alucc_pkg::COND_ALWAYS: return 1'b1;
      alucc_pkg::COND_LE: return lt | z;
      alucc_pkg::COND_L: return lt;
      alucc_pkg::COND_E: return z;
      alucc_pkg::COND_NE: return ~z;
      alucc_pkg::COND_GE: return ~lt;
      alucc_pkg::COND_G: return ~lt & ~z;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_field(string field, logic [alucc_pkg::DATA_W-1:0] exp_v,
                              logic [alucc_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch expected %h actual %h", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    alu_outcome_t                 exp_o;
    alu_outcome_t                 new_o;
    logic [3:0]                   fn;
    logic [alucc_pkg::DATA_W-1:0] r;
    if (rst) begin
      outcome_q.delete();
      cc_zero = 1'b1;
      cc_sign = 1'b0;
      cc_ovf = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction result %h", $time, result);
        end else begin
          exp_o = outcome_q.pop_front();
          compared++;
          report_field("result", exp_o.value, result);
          report_field("zero_out", exp_o.zero, zero_out);
          report_field("sign_out", exp_o.sign, sign_out);
          report_field("overflow_out", exp_o.overflow, overflow_out);
          report_field("cond_true", exp_o.cond, cond_true);
        end
      end
      if (in_valid && !in_stall) begin
        fn = set_flags ? mode : alucc_pkg::MODE_ADD;
        r = alu_function(fn, operand_a, operand_b);
        if (set_flags) begin
          cc_zero = (r == '0);
          cc_sign = r[alucc_pkg::DATA_W-1];
          if (fn == alucc_pkg::MODE_ADD)
            cc_ovf = (operand_a[alucc_pkg::DATA_W-1] ^ r[alucc_pkg::DATA_W-1])
                     & (operand_b[alucc_pkg::DATA_W-1] ^ r[alucc_pkg::DATA_W-1]);
        end
        new_o.value = r;
        new_o.zero = cc_zero;
        new_o.sign = cc_sign;
        new_o.overflow = cc_ovf;
        new_o.cond = branch_taken(cc_zero, cc_sign, cc_ovf, cond_sel);
        outcome_q.push_back(new_o);
      end
    end
    fail_count <= errors;
    pending <= outcome_q.size();
    checked <= compared;
  end

endmodule

[bench/alu_with_condition_codes_tb.sv]
// testbench top: clock, reset, stimulus and verdict for the alu with condition codes
module alu_with_condition_codes_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW = alucc_pkg::DATA_W;
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [3:0] MODE_UNDEF_LO = 4'd11;
  localparam logic [3:0] MODE_UNDEF_HI = 4'd15;
  localparam logic [3:0] COND_NEVER_LO = 4'd7;
  localparam logic [3:0] COND_NEVER_HI = 4'd15;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [DW-1:0] operand_a = '0;
  logic signed [DW-1:0] operand_b = '0;
  logic [3:0]           mode = alucc_pkg::MODE_ADD;
  logic                 set_flags = 1'b0;
  logic [3:0]           cond_sel = alucc_pkg::COND_ALWAYS;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] result;
  logic                 zero_out;
  logic                 sign_out;
  logic                 overflow_out;
  logic                 cond_true;

  int fail_count;
  int pending;
  int checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  alu_with_condition_codes dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operand_a(operand_a), .operand_b(operand_b),
    .mode(mode), .set_flags(set_flags), .cond_sel(cond_sel),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .zero_out(zero_out), .sign_out(sign_out),
    .overflow_out(overflow_out), .cond_true(cond_true)
  );

  alu_with_condition_codes_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operand_a(operand_a), .operand_b(operand_b),
    .mode(mode), .set_flags(set_flags), .cond_sel(cond_sel),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .zero_out(zero_out), .sign_out(sign_out),
    .overflow_out(overflow_out), .cond_true(cond_true),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("alu_with_condition_codes_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_op(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                         logic [3:0] m, logic sf, logic [3:0] cs);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    mode <= m;
    set_flags <= sf;
    cond_sel <= cs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return S_MIN;
      3: return S_MAX;
      4: return $signed(DW'($urandom_range(130))) - 64'sd64;
      5: return {$urandom, $urandom} & 64'hFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic [3:0]           m;
    a = pick_operand();
    b = ($urandom_range(9) == 0) ? a : pick_operand();
    m = ($urandom_range(99) < 88) ? 4'($urandom_range(alucc_pkg::MODE_MUL))
                                  : 4'($urandom_range(MODE_UNDEF_HI, MODE_UNDEF_LO));
    send_op(a, b, m, ($urandom_range(99) < 85), 4'($urandom_range(15)));
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 52, 0, 29};
    stall_tab = '{0, 0, 52, 29};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_op(S_MAX, 64'sd1, alucc_pkg::MODE_ADD, 1'b1, alucc_pkg::COND_L);
    send_op(S_MIN, -64'sd1, alucc_pkg::MODE_ADD, 1'b1, alucc_pkg::COND_GE);
    send_op(64'sd5, -64'sd5, alucc_pkg::MODE_ADD, 1'b1, alucc_pkg::COND_E);
    send_op(64'sd3, 64'sd1, alucc_pkg::MODE_SUB, 1'b1, alucc_pkg::COND_LE);
    send_op(64'sd9, 64'sd9, alucc_pkg::MODE_SUB, 1'b1, alucc_pkg::COND_NE);
    send_op(-64'sd1, S_MIN, alucc_pkg::MODE_AND, 1'b1, alucc_pkg::COND_G);
    send_op(S_MAX, -64'sd1, alucc_pkg::MODE_XOR, 1'b1, alucc_pkg::COND_G);
    send_op(64'sd63, 64'sd1, alucc_pkg::MODE_SHL, 1'b1, alucc_pkg::COND_L);
    send_op(64'sd70, 64'sd3, alucc_pkg::MODE_SHL2, 1'b1, alucc_pkg::COND_ALWAYS);
    send_op(64'sd4, -64'sd1, alucc_pkg::MODE_SHR, 1'b1, alucc_pkg::COND_GE);
    send_op(64'sd63, S_MIN, alucc_pkg::MODE_SAR, 1'b1, alucc_pkg::COND_LE);
    send_op(64'sd129, S_MAX, alucc_pkg::MODE_SAR, 1'b1, alucc_pkg::COND_E);
    send_op(S_MIN, S_MAX, alucc_pkg::MODE_MAX, 1'b1, alucc_pkg::COND_G);
    send_op(S_MIN, S_MAX, alucc_pkg::MODE_MIN, 1'b1, alucc_pkg::COND_L);
    send_op(-64'sd7, -64'sd7, alucc_pkg::MODE_MAX, 1'b1, alucc_pkg::COND_NE);
    send_op(S_MAX, S_MAX, alucc_pkg::MODE_MUL, 1'b1, alucc_pkg::COND_LE);
    send_op(S_MIN, -64'sd1, alucc_pkg::MODE_MUL, 1'b1, alucc_pkg::COND_ALWAYS);
    send_op(S_MAX, 64'sd1, alucc_pkg::MODE_ADD, 1'b1, alucc_pkg::COND_L);
    send_op(-64'sd4, 64'sd2, MODE_UNDEF_LO, 1'b1, alucc_pkg::COND_L);
    send_op(S_MIN, S_MIN, MODE_UNDEF_HI, 1'b1, alucc_pkg::COND_ALWAYS);
    send_op(S_MAX, S_MAX, alucc_pkg::MODE_XOR, 1'b0, COND_NEVER_LO);
    send_op(64'sd1, -64'sd1, alucc_pkg::MODE_SAR, 1'b0, COND_NEVER_HI);
    send_op(64'sd2, 64'sd2, alucc_pkg::MODE_SUB, 1'b1, COND_NEVER_HI);
    send_op(64'sd0, 64'sd0, MODE_UNDEF_HI, 1'b0, COND_NEVER_LO);

    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 410; k++) begin
        if ((k % 100) < 15) begin
          idle_pct = 0;
          stall_pct = 0;
        end else begin
          idle_pct = idle_tab[p];
          stall_pct = stall_tab[p];
        end
        if (p == 2 && k == 200) drain();
        send_random();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("sent %0d transactions of all functions and conditions over four idle/stall phases",
             sent);
    $display("compared %0d results field by field", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("alu_with_condition_codes_tb passed");
    end else begin
      $display("alu_with_condition_codes_tb failed");
    end
    $finish;
  end

endmodule
